// File: src/ntsm_pkg.sv
// Shared types and constants for the nearest template SSE match core.
// No dependencies; imported by every module in src.
package ntsm_pkg;

   localparam int NUM_TMPL = 4;
   localparam int ELEM_W   = 16;
   localparam int DIFF_W   = 16;                 // |a - b| of two 16 bit signed values
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int SUM_W    = 48;
   localparam int CODE_W   = 3;
   localparam int LED_W    = 4;

   // Nominal matrix side; the decision itself is driven by the last flag only.
   localparam int MATRIX_SIDE = 16;

   localparam logic [SUM_W-1:0]  SUM_MAX      = {SUM_W{1'b1}};
   localparam logic [SUM_W-1:0]  THRESH_RESET = 48'd167772160;  // 10.0 in Q24.24
   localparam logic [CODE_W-1:0] MATCH_NONE   = 3'd4;
   localparam logic [LED_W-1:0]  LEDS_NONE    = 4'd14;         // D4, D5, D6

   typedef logic [NUM_TMPL-1:0][ELEM_W-1:0] elems_type;
   typedef logic [NUM_TMPL-1:0][DIFF_W-1:0] diffs_type;
   typedef logic [NUM_TMPL-1:0][SQ_W-1:0]   squares_type;
   typedef logic [NUM_TMPL-1:0][SUM_W-1:0]  sums_type;

   // Control that travels with a beat between pipeline stages.
   typedef struct packed {
      logic valid;
      logic last;
   } beat_ctl_type;

endpackage

// File: src/ntsm_sq_stage.sv
// Input register (absolute differences) and squaring register.
// Depends on ntsm_pkg.
module ntsm_sq_stage
   import ntsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  elems_type    tmpl_elems,
   input  logic [ELEM_W-1:0] probe_elem,
   input  logic         last_elem,
   input  logic         dn_take,
   output beat_ctl_type sq_ctl,
   output squares_type  sq_vals
);

   beat_ctl_type s1_ctl_ff, s1_ctl_in;
   diffs_type    s1_diff_ff, s1_diff_in;
   beat_ctl_type s2_ctl_ff, s2_ctl_in;
   squares_type  s2_sq_ff, s2_sq_in;
   logic         s1_ready, s2_ready, accept;

   assign s2_ready  = !s2_ctl_ff.valid || dn_take;
   assign s1_ready  = !s1_ctl_ff.valid || s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   always_comb begin
      logic signed [ELEM_W:0] d;
      d          = '0;
      s1_diff_in = s1_diff_ff;
      s1_ctl_in  = s1_ctl_ff;
      if (accept) begin
         for (int i = 0; i < NUM_TMPL; i++) begin
            d = {tmpl_elems[i][ELEM_W-1], tmpl_elems[i]} - {probe_elem[ELEM_W-1], probe_elem};
            s1_diff_in[i] = d[ELEM_W] ? DIFF_W'(-d) : DIFF_W'(d);
         end
         s1_ctl_in = '{valid: 1'b1, last: last_elem};
      end else if (s2_ready) begin
         s1_ctl_in.valid = 1'b0;
      end
   end

   always_comb begin
      s2_sq_in  = s2_sq_ff;
      s2_ctl_in = s2_ctl_ff;
      if (s2_ready) begin
         s2_ctl_in = s1_ctl_ff;
         for (int i = 0; i < NUM_TMPL; i++) begin
            s2_sq_in[i] = s1_diff_ff[i] * s1_diff_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_diff_ff <= s1_diff_in;
      s2_sq_ff   <= s2_sq_in;
   end

   assign sq_ctl  = s2_ctl_ff;
   assign sq_vals = s2_sq_ff;

endmodule

// File: src/ntsm_accum.sv
// Four saturating SSE accumulators and the final-sum register.
// Depends on ntsm_pkg.
module ntsm_accum
   import ntsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  beat_ctl_type sq_ctl,
   input  squares_type  sq_vals,
   output logic         take,
   input  logic         dn_ready,
   output logic         fin_valid,
   output sums_type     fin_sums
);

   sums_type acc_ff, acc_in;
   sums_type fin_ff, fin_in;
   sums_type acc_next;
   logic     fin_v_ff, fin_v_in;
   logic     fin_ready;

   assign fin_ready = !fin_v_ff || dn_ready;
   assign take      = sq_ctl.valid && (!sq_ctl.last || fin_ready);

   always_comb begin
      logic [SUM_W:0] s;
      for (int i = 0; i < NUM_TMPL; i++) begin
         s = {1'b0, acc_ff[i]} + (SUM_W+1)'(sq_vals[i]);
         acc_next[i] = s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      fin_in   = fin_ff;
      fin_v_in = fin_v_ff && !dn_ready;
      if (take) begin
         acc_in = acc_next;
         if (sq_ctl.last) begin
            acc_in   = '0;
            fin_in   = acc_next;
            fin_v_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         fin_v_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         fin_v_ff <= fin_v_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
   end

   assign fin_valid = fin_v_ff;
   assign fin_sums  = fin_ff;

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      take && sq_ctl.last |=> acc_ff == '0)
      else $error("sums not cleared after last beat");
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      fin_v_ff && !dn_ready |=> fin_v_ff && $stable(fin_ff))
      else $error("final sums lost while downstream busy");
   a_last_blocked: assert property (@(posedge clock) disable iff (reset)
      sq_ctl.valid && sq_ctl.last && !fin_ready |-> !take)
      else $error("last beat taken with final register full");

endmodule

// File: src/ntsm_decide.sv
// Threshold register, match decision and result register.
// Depends on ntsm_pkg.
module ntsm_decide
   import ntsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SUM_W-1:0]  csr_wr_data,
   input  logic              fin_valid,
   input  sums_type          fin_sums,
   output logic              up_ready,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_match_code,
   output logic [LED_W-1:0]  rsp_led_pattern,
   output sums_type          rsp_errors
);

   logic [SUM_W-1:0]  thr_ff, thr_in;
   logic              rv_ff, rv_in;
   logic [CODE_W-1:0] code_ff, code_in, code_c;
   logic [LED_W-1:0]  led_ff, led_in, led_c;
   sums_type          err_ff, err_in;
   logic [NUM_TMPL-1:0] win;
   logic              load;

   assign up_ready = !rv_ff || !rsp_stall;
   assign load     = fin_valid && up_ready;
   assign thr_in   = csr_wr_en ? csr_wr_data : thr_ff;

   // A template wins only if strictly below threshold and all others.
   always_comb begin
      for (int i = 0; i < NUM_TMPL; i++) begin
         win[i] = fin_sums[i] < thr_ff;
         for (int j = 0; j < NUM_TMPL; j++) begin
            if (j != i && !(fin_sums[i] < fin_sums[j])) begin
               win[i] = 1'b0;
            end
         end
      end
      code_c = MATCH_NONE;
      led_c  = LEDS_NONE;
      for (int i = NUM_TMPL - 1; i >= 0; i--) begin
         if (win[i]) begin
            code_c = CODE_W'(i);
            led_c  = LED_W'(1) << i;
         end
      end
   end

   always_comb begin
      code_in = code_ff;
      led_in  = led_ff;
      err_in  = err_ff;
      rv_in   = rv_ff && rsp_stall;
      if (load) begin
         code_in = code_c;
         led_in  = led_c;
         err_in  = fin_sums;
         rv_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
         rv_ff  <= 1'b0;
      end else begin
         thr_ff <= thr_in;
         rv_ff  <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      led_ff  <= led_in;
      err_ff  <= err_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_match_code  = code_ff;
   assign rsp_led_pattern = led_ff;
   assign rsp_errors      = err_ff;

   a_none_leds: assert property (@(posedge clock) disable iff (reset)
      rv_ff && code_ff == MATCH_NONE |-> led_ff == LEDS_NONE)
      else $error("no-match LED pattern wrong");
   a_win_onehot: assert property (@(posedge clock) disable iff (reset)
      rv_ff && code_ff != MATCH_NONE |-> $onehot(led_ff) && code_ff < MATCH_NONE)
      else $error("winner LED pattern not one-hot");
   a_win_below_thr: assert property (@(posedge clock) disable iff (reset)
      load && code_c != MATCH_NONE |-> fin_sums[code_c[1:0]] < thr_ff)
      else $error("winner not below threshold");

endmodule

// File: src/nearest_template_sse_match_core.sv
// Top level of the nearest template SSE match core.
// Depends on ntsm_pkg, ntsm_sq_stage, ntsm_accum, ntsm_decide.
//
//   port group  | dir | handshake            | beat contents
//   req_*       | in  | req_valid/req_stall  | four template elements, probe element, last flag
//   rsp_*       | out | rsp_valid/rsp_stall  | match code, LED pattern, four error sums
//   csr_*       | in  | csr_wr_en            | reject threshold, Q24.24
//
// One beat is accepted per cycle when nothing downstream is full.
// A last beat accepted at the input passes through the abs-diff register, the squaring
// register and the final-sum register, then reaches the result register.
// The 48 bit saturating accumulate is the single per-beat feedback loop.
// A stalled result only blocks a following last beat; non-last beats keep flowing.
// Reset (synchronous) clears sums and valids and sets the threshold to 10.0.
module nearest_template_sse_match_core
   import ntsm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [ELEM_W-1:0] req_tmpl_a_elem,
   input  logic signed [ELEM_W-1:0] req_tmpl_b_elem,
   input  logic signed [ELEM_W-1:0] req_tmpl_c_elem,
   input  logic signed [ELEM_W-1:0] req_tmpl_d_elem,
   input  logic signed [ELEM_W-1:0] req_probe_elem,
   input  logic                     req_last_elem,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CODE_W-1:0]        rsp_match_code,
   output logic [LED_W-1:0]         rsp_led_pattern,
   output logic [SUM_W-1:0]         rsp_error_a,
   output logic [SUM_W-1:0]         rsp_error_b,
   output logic [SUM_W-1:0]         rsp_error_c,
   output logic [SUM_W-1:0]         rsp_error_d,
   input  logic                     csr_wr_en,
   input  logic [SUM_W-1:0]         csr_wr_data
);

   elems_type    tmpl_elems;
   beat_ctl_type sq_ctl;
   squares_type  sq_vals;
   logic         take;
   logic         fin_valid;
   sums_type     fin_sums;
   logic         dec_ready;
   sums_type     errors;

   assign tmpl_elems[0] = req_tmpl_a_elem;
   assign tmpl_elems[1] = req_tmpl_b_elem;
   assign tmpl_elems[2] = req_tmpl_c_elem;
   assign tmpl_elems[3] = req_tmpl_d_elem;

   ntsm_sq_stage u_sq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .tmpl_elems (tmpl_elems),
      .probe_elem (req_probe_elem),
      .last_elem  (req_last_elem),
      .dn_take    (take),
      .sq_ctl     (sq_ctl),
      .sq_vals    (sq_vals)
   );

   ntsm_accum u_acc (
      .clock     (clock),
      .reset     (reset),
      .sq_ctl    (sq_ctl),
      .sq_vals   (sq_vals),
      .take      (take),
      .dn_ready  (dec_ready),
      .fin_valid (fin_valid),
      .fin_sums  (fin_sums)
   );

   ntsm_decide u_dec (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fin_valid       (fin_valid),
      .fin_sums        (fin_sums),
      .up_ready        (dec_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_code  (rsp_match_code),
      .rsp_led_pattern (rsp_led_pattern),
      .rsp_errors      (errors)
   );

   assign rsp_error_a = errors[0];
   assign rsp_error_b = errors[1];
   assign rsp_error_c = errors[2];
   assign rsp_error_d = errors[3];

endmodule

// File: dv/tb.sv
// Self-checking bench for nearest_template_sse_match_core: directed and random streams of
// template/probe beats, checked against an in-bench SSE predictor and match decision.
// Depends on ntsm_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb
   import ntsm_pkg::*;
();

   localparam int SETTLE_CYCLES  = 8;      // lets non-last beats reach the sums
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
   localparam int OVF_BEATS      = 64;     // long matrix of full-scale squares
   localparam int MAX_REPORTS    = 10;

   typedef enum logic {STIM_BEAT, STIM_THRESH} stim_kind_type;

   // One entry of the stimulus queue: a data beat or a threshold write.
   typedef struct packed {
      stim_kind_type     kind;
      logic              rush;     // no sender gap in front of the following beat
      elems_type         tmpl;     // [0] is template a
      logic [ELEM_W-1:0] probe;
      logic              last;
      logic [SUM_W-1:0]  thresh;
   } stim_type;

   // What the core should report for one matrix.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LED_W-1:0]  leds;
      sums_type          errs;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_tmpl_a_elem = '0;
   logic signed [ELEM_W-1:0] req_tmpl_b_elem = '0;
   logic signed [ELEM_W-1:0] req_tmpl_c_elem = '0;
   logic signed [ELEM_W-1:0] req_tmpl_d_elem = '0;
   logic signed [ELEM_W-1:0] req_probe_elem  = '0;
   logic                     req_last_elem   = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [CODE_W-1:0]        rsp_match_code;
   logic [LED_W-1:0]         rsp_led_pattern;
   logic [SUM_W-1:0]         rsp_error_a;
   logic [SUM_W-1:0]         rsp_error_b;
   logic [SUM_W-1:0]         rsp_error_c;
   logic [SUM_W-1:0]         rsp_error_d;
   logic                     csr_wr_en   = 1'b0;
   logic [SUM_W-1:0]         csr_wr_data = THRESH_RESET;

   nearest_template_sse_match_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_tmpl_a_elem (req_tmpl_a_elem),
      .req_tmpl_b_elem (req_tmpl_b_elem),
      .req_tmpl_c_elem (req_tmpl_c_elem),
      .req_tmpl_d_elem (req_tmpl_d_elem),
      .req_probe_elem  (req_probe_elem),
      .req_last_elem   (req_last_elem),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_match_code  (rsp_match_code),
      .rsp_led_pattern (rsp_led_pattern),
      .rsp_error_a     (rsp_error_a),
      .rsp_error_b     (rsp_error_b),
      .rsp_error_c     (rsp_error_c),
      .rsp_error_d     (rsp_error_d),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Predictor state: running sums and the threshold as the core holds them.
   // ---------------------------------------------------------------
   stim_type         stim_q[$];
   verdict_type      pending_verdicts[$];
   sums_type         sse_sums;
   logic [SUM_W-1:0] thresh_model;
   int               fail_count = 0;

   // Fold one accepted beat into the sums; on the last beat, decide and queue the verdict.
   task automatic accumulate_sse(input stim_type s);
      logic signed [ELEM_W:0] diff;
      logic [DIFF_W-1:0]      mag;
      logic [SQ_W-1:0]        sq;
      logic [SUM_W:0]         total;
      logic                   wins;
      logic                   found;
      verdict_type            v;
      for (int i = 0; i < NUM_TMPL; i++) begin
         diff  = $signed({s.tmpl[i][ELEM_W-1], s.tmpl[i]})
               - $signed({s.probe[ELEM_W-1], s.probe});
         mag   = diff[ELEM_W] ? DIFF_W'(-diff) : DIFF_W'(diff);
         sq    = SQ_W'(mag) * SQ_W'(mag);
         total = {1'b0, sse_sums[i]} + (SUM_W+1)'(sq);
         // saturate at the top of Q24.24
         sse_sums[i] = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
      end
      if (s.last) begin
         v.code = MATCH_NONE;
         v.leds = LEDS_NONE;
         found  = 1'b0;
         // strictly lowest and strictly under threshold; a tie means nobody wins
         for (int i = 0; i < NUM_TMPL; i++) begin
            if (!found) begin
               wins = sse_sums[i] < thresh_model;
               for (int j = 0; j < NUM_TMPL; j++) begin
                  if (j != i && !(sse_sums[i] < sse_sums[j])) begin
                     wins = 1'b0;
                  end
               end
               if (wins) begin
                  v.code = CODE_W'(i);
                  v.leds = LED_W'(1) << i;
                  found  = 1'b1;
               end
            end
         end
         v.errs   = sse_sums;
         sse_sums = '0;
         pending_verdicts.push_back(v);
      end
   endtask

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("FAIL @%0t: %s", $realtime, msg);
      end
   endtask

   // ---------------------------------------------------------------
   // Driver: pops the stimulus queue; beats get random gaps, threshold
   // writes wait until the core has drained.
   // ---------------------------------------------------------------
   stim_type cur_beat;
   int       gap_left   = 0;
   int       settle_cnt = 0;
   bit       tx_burst   = 1'b0;

   always @(posedge clock) begin
      logic next_valid;
      logic next_wr;
      if (reset) begin
         req_valid    <= 1'b0;
         csr_wr_en    <= 1'b0;
         sse_sums     = '0;
         thresh_model = THRESH_RESET;
         gap_left     = 0;
         settle_cnt   = 0;
      end else begin
         next_valid = req_valid;
         next_wr    = 1'b0;
         if (req_valid && !req_stall) begin
            accumulate_sse(cur_beat);
            next_valid = 1'b0;
            // occasionally flip into or out of back-to-back mode
            if ($urandom_range(0, 31) == 0) begin
               tx_burst = !tx_burst;
            end
            gap_left = (cur_beat.rush || tx_burst) ? 0 : $urandom_range(0, 14);
         end
         if (!next_valid && stim_q.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (stim_q[0].kind == STIM_BEAT) begin
               cur_beat = stim_q.pop_front();
               req_tmpl_a_elem <= cur_beat.tmpl[0];
               req_tmpl_b_elem <= cur_beat.tmpl[1];
               req_tmpl_c_elem <= cur_beat.tmpl[2];
               req_tmpl_d_elem <= cur_beat.tmpl[3];
               req_probe_elem  <= cur_beat.probe;
               req_last_elem   <= cur_beat.last;
               next_valid = 1'b1;
               settle_cnt = 0;
            end else if (pending_verdicts.size() != 0) begin
               settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYCLES) begin
               // non-last beats may still be in the pipe
               settle_cnt++;
            end else begin
               cur_beat     = stim_q.pop_front();
               thresh_model = cur_beat.thresh;
               csr_wr_data  <= cur_beat.thresh;
               next_wr      = 1'b1;
               settle_cnt   = 0;
            end
         end
         req_valid <= next_valid;
         csr_wr_en <= next_wr;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: random per-beat stall on the result side plus two long
   // hold-offs, compare each accepted result with the oldest verdict.
   // ---------------------------------------------------------------
   int stall_left   = 0;
   int hold_left    = 0;
   int results_seen = 0;
   bit rx_burst     = 1'b0;

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_left   = 0;
         hold_left    = 0;
         results_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.code    = rsp_match_code;
            got.leds    = rsp_led_pattern;
            got.errs[0] = rsp_error_a;
            got.errs[1] = rsp_error_b;
            got.errs[2] = rsp_error_c;
            got.errs[3] = rsp_error_d;
            results_seen++;
            if (pending_verdicts.size() == 0) begin
               note_failure($sformatf("result %0d with nothing expected", results_seen));
            end else begin
               want = pending_verdicts.pop_front();
               if (got.code !== want.code || got.leds !== want.leds ||
                   got.errs[0] !== want.errs[0] || got.errs[1] !== want.errs[1] ||
                   got.errs[2] !== want.errs[2] || got.errs[3] !== want.errs[3]) begin
                  note_failure($sformatf(
                     {"result %0d exp code %0d leds %h sse %h %h %h %h",
                      " / got code %0d leds %h sse %h %h %h %h"},
                     results_seen, want.code, want.leds,
                     want.errs[0], want.errs[1], want.errs[2], want.errs[3],
                     got.code, got.leds, got.errs[0], got.errs[1], got.errs[2], got.errs[3]));
               end
            end
            if ($urandom_range(0, 15) == 0) begin
               rx_burst = !rx_burst;
            end
            stall_left = rx_burst ? 0 : $urandom_range(0, 14);
            // long hold-off: the next last beat backs up and the core stalls its input
            if (results_seen == 30 || results_seen == 90) begin
               hold_left = HOLD_CYCLES;
            end
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0) || (stall_left > 0);
      end
   end

   // Watchdog: a run with no handshake for too long is a hang.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------
   task automatic push_beat(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                            input logic [ELEM_W-1:0] c, input logic [ELEM_W-1:0] d,
                            input logic [ELEM_W-1:0] p, input logic last, input logic rush);
      stim_type s;
      s.kind    = STIM_BEAT;
      s.rush    = rush;
      s.tmpl[0] = a;
      s.tmpl[1] = b;
      s.tmpl[2] = c;
      s.tmpl[3] = d;
      s.probe   = p;
      s.last    = last;
      s.thresh  = '0;
      stim_q.push_back(s);
   endtask

   task automatic push_thresh(input logic [SUM_W-1:0] value);
      stim_type s;
      s        = '0;
      s.kind   = STIM_THRESH;
      s.thresh = value;
      stim_q.push_back(s);
   endtask

   // Template element near the probe; the class sets how far it strays.
   function automatic logic [ELEM_W-1:0] jitter_elem(input logic [ELEM_W-1:0] p, input int cls);
      int span;
      case (cls)
         0: span = 0;
         1: span = 15;
         2: span = 255;
         3: span = 4095;
         default: return ELEM_W'($urandom);
      endcase
      return ELEM_W'(int'(p) + int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // One threshold setting, then mostly well-formed matrices with random content,
   // a few full-size ones, some deliberate ties and some noise beats.
   task automatic random_phase(input logic [SUM_W-1:0] thr, input int n_items);
      int                pushed;
      int                len;
      int                twin;
      int                cls[NUM_TMPL];
      logic [ELEM_W-1:0] p;
      logic [ELEM_W-1:0] e[NUM_TMPL];
      pushed = 0;
      push_thresh(thr);
      while (pushed < n_items) begin
         if ($urandom_range(0, 7) == 0) begin
            push_beat(ELEM_W'($urandom), ELEM_W'($urandom), ELEM_W'($urandom),
                      ELEM_W'($urandom), ELEM_W'($urandom), 1'($urandom_range(0, 1)), 1'b0);
            pushed++;
         end else begin
            len = ($urandom_range(0, 39) == 0) ? MATRIX_SIDE * MATRIX_SIDE
                                               : $urandom_range(1, MATRIX_SIDE);
            for (int k = 0; k < NUM_TMPL; k++) begin
               cls[k] = $urandom_range(0, 4);
            end
            // twin > 0: template twin copies its neighbor below, forcing a tie
            twin = ($urandom_range(0, 5) == 0) ? $urandom_range(1, NUM_TMPL - 1) : 0;
            for (int n = 0; n < len; n++) begin
               case ($urandom_range(0, 19))
                  0:       p = 16'h7FFF;
                  1:       p = 16'h8000;
                  2:       p = 16'h0000;
                  default: p = ELEM_W'($urandom);
               endcase
               for (int k = 0; k < NUM_TMPL; k++) begin
                  e[k] = jitter_elem(p, cls[k]);
               end
               if (twin != 0) begin
                  e[twin] = e[twin - 1];
               end
               push_beat(e[0], e[1], e[2], e[3], p, n == len - 1, 1'b0);
            end
            pushed += len;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Test sequence. 1.0 in Q4.12 is 4096; its square is 1.0 in Q8.24.
   // ---------------------------------------------------------------
   initial begin
      // reset threshold (10.0): every template wins at least once, ties and misses
      push_beat(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0);            // four-way tie
      push_beat(16'sd0, 16'sd4096, 16'sd8192, -16'sd8192, 16'sd0, 1'b1, 1'b0);  // a wins
      push_beat(16'sd4096, 16'sd0, 16'sd8192, 16'sd12288, 16'sd0, 1'b1, 1'b0);  // b wins
      push_beat(16'sd8192, -16'sd8192, 16'sd0, 16'sd4096, 16'sd0, 1'b1, 1'b0);  // c wins
      push_beat(16'sd4096, -16'sd4096, 16'sd8192, 16'sd0, 16'sd0, 1'b1, 1'b0);  // d wins
      push_beat(16'sd0, 16'sd0, 16'sd4096, 16'sd4096, 16'sd0, 1'b1, 1'b0);      // tie at the bottom
      // 16.0, too big
      push_beat(16'sd16384, -16'sd20480, 16'sd32767, 16'h8000, 16'sd0, 1'b1, 1'b0);
      push_beat(16'sd32767, 16'h8000, 16'sd32767, 16'h8000, 16'sd32767, 1'b1, 1'b0);
      push_beat(16'h8000, 16'sd32767, -16'sd32767, 16'sd0, 16'h8000, 1'b1, 1'b0);
      // 9.0 wins
      push_beat(16'sd12288, 16'sd16384, -16'sd16384, 16'sd20480, 16'sd0, 1'b1, 1'b0);
      // ten beats of 1.0 land exactly on the 10.0 threshold: no match
      for (int n = 0; n < 10; n++) begin
         push_beat(16'sd4096, 16'sd8192, -16'sd8192, 16'sd8192, 16'sd0, n == 9, 1'b0);
      end

      // threshold of one LSB: zero wins, one LSB does not
      push_thresh(SUM_W'(1));
      push_beat(16'sd100, 16'sd200, 16'sd300, -16'sd100, 16'sd100, 1'b1, 1'b0);
      push_beat(16'sd101, 16'sd200, 16'sd300, -16'sd100, 16'sd100, 1'b1, 1'b0);

      // zero threshold: nothing can win
      push_thresh('0);
      push_beat(16'sd7, 16'sd200, 16'sd300, -16'sd100, 16'sd7, 1'b1, 1'b0);

      // full-scale threshold: a large but lowest sum wins, then a long matrix
      // of full-scale squares back to back
      push_thresh(SUM_MAX);
      push_beat(16'sd32767, 16'h8000, -16'sd30000, 16'sd20000, 16'sd0, 1'b1, 1'b0);
      for (int n = 0; n < OVF_BEATS; n++) begin
         push_beat(16'sd32767, 16'h8000, 16'sd32767, 16'sd32767, 16'h8000,
                   n == OVF_BEATS - 1, 1'b1);
      end

      random_phase(THRESH_RESET, 300);
      random_phase(SUM_W'({$urandom, $urandom}) >> 20, 300);
      random_phase(SUM_W'({$urandom, $urandom}), 300);
      random_phase(SUM_MAX, 300);
      random_phase('0, 150);
      random_phase(THRESH_RESET, 150);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || req_valid || csr_wr_en) begin
         @(posedge clock);
      end
      while (pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
      end

      if (fail_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
